[rtl/parent_table_with_dirty_marks_defines.svh]
// Assertion macros used by the table controller, pdm_ctrl.
`ifndef PARENT_TABLE_WITH_DIRTY_MARKS_DEFINES_SVH
`define PARENT_TABLE_WITH_DIRTY_MARKS_DEFINES_SVH

// Condition holds at every clock edge out of reset.
`define PDM_ASSERT_HOLDS(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define PDM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define PDM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

[rtl/pdm_pkg.sv]
package pdm_pkg;

	localparam int MODE_W = 3;
	localparam int IDX_W  = 6;
	localparam int OCNT_W = 7;

	// Operation codes
	typedef enum logic [MODE_W-1:0] {
		MODE_APPEND = 3'd0,
		MODE_ATTACH = 3'd1,
		MODE_TOUCH  = 3'd2,
		MODE_LOOKUP = 3'd3,
		MODE_CLEAR  = 3'd4
	} mode_t;

	// One parent link entry
	typedef struct packed {
		logic             detached;
		logic [IDX_W-1:0] parent;
	} link_t;

	// Memory control from the sequencer to the store
	typedef struct packed {
		logic rd_en;
		logic link_we;
		logic dirty_we;
		logic dirty_wdata;
	} mem_ctl_t;

	// One result word
	typedef struct packed {
		logic              ok;
		logic [IDX_W-1:0]  new_index;
		logic [IDX_W-1:0]  node_parent;
		logic              node_detached;
		logic              node_dirty;
		logic [OCNT_W-1:0] entry_count;
		logic [OCNT_W-1:0] dirty_count;
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_READ,
		ST_NODE,
		ST_WALK,
		ST_EMIT
	} state_t;

endpackage

[rtl/pdm_ifs.sv]
interface pdm_req_if;
	import pdm_pkg::*;

	logic             valid;
	logic             ready;
	logic [MODE_W-1:0] mode;
	logic [IDX_W-1:0] node_index;
	logic [IDX_W-1:0] parent_index;
	logic             detach;

	modport source (output valid, mode, node_index, parent_index, detach, input ready);
	modport sink (input valid, mode, node_index, parent_index, detach, output ready);
endinterface

interface pdm_rsp_if;
	import pdm_pkg::*;

	logic              valid;
	logic              ready;
	logic              ok;
	logic [IDX_W-1:0]  new_index;
	logic [IDX_W-1:0]  node_parent;
	logic              node_detached;
	logic              node_dirty;
	logic [OCNT_W-1:0] entry_count;
	logic [OCNT_W-1:0] dirty_count;

	modport source (output valid, ok, new_index, node_parent, node_detached, node_dirty,
		entry_count, dirty_count, input ready);
	modport sink (input valid, ok, new_index, node_parent, node_detached, node_dirty,
		entry_count, dirty_count, output ready);
endinterface

[rtl/pdm_store.sv]
module pdm_store #(
	parameter int ENTRIES = 64,
	localparam int AW = $clog2(ENTRIES)
) (
	input  logic              clk,
	input  pdm_pkg::mem_ctl_t mem_ctl,
	input  logic [AW-1:0]     rd_addr,
	input  logic [AW-1:0]     wr_addr,
	input  pdm_pkg::link_t    link_wdata,
	output pdm_pkg::link_t    rd_link,
	output logic              rd_dirty
);
	import pdm_pkg::*;

	link_t link_mem [ENTRIES];
	logic  dirty_mem [ENTRIES];

	// Write ports
	always_ff @(posedge clk) begin
		if (mem_ctl.link_we) begin
			link_mem[wr_addr] <= link_wdata;
		end
		if (mem_ctl.dirty_we) begin
			dirty_mem[wr_addr] <= mem_ctl.dirty_wdata;
		end
	end

	// Registered read
	always_ff @(posedge clk) begin
		if (mem_ctl.rd_en) begin
			rd_link  <= link_mem[rd_addr];
			rd_dirty <= dirty_mem[rd_addr];
		end
	end

endmodule

[rtl/pdm_ctrl.sv]
`include "parent_table_with_dirty_marks_defines.svh"

module pdm_ctrl #(
	parameter int ENTRIES = 64,
	parameter int DEPTH_LIMIT = 16,
	localparam int AW = $clog2(ENTRIES)
) (
	input  logic              clk,
	input  logic              arst_n,
	pdm_req_if.sink           req,
	output pdm_pkg::mem_ctl_t mem_ctl,
	output logic [AW-1:0]     rd_addr,
	output logic [AW-1:0]     wr_addr,
	output pdm_pkg::link_t    link_wdata,
	input  pdm_pkg::link_t    rd_link,
	input  logic              rd_dirty,
	output logic              res_valid,
	output pdm_pkg::res_t     res,
	input  logic              res_ready
);
	import pdm_pkg::*;

	localparam int CW = $clog2(ENTRIES + 1);
	localparam int KW = (CW > IDX_W) ? CW : IDX_W;
	localparam int SW = $clog2(DEPTH_LIMIT + 1);
	localparam logic [CW-1:0] ENT_C = CW'(ENTRIES);
	localparam logic [SW-1:0] LIM_C = SW'(DEPTH_LIMIT);

	state_t            state_q, state_d;
	logic [MODE_W-1:0] mode_q, mode_d;
	logic [IDX_W-1:0]  node_q, node_d;
	logic [IDX_W-1:0]  parent_q, parent_d;
	logic              detach_q, detach_d;
	logic              pass_q, pass_d;
	logic [CW-1:0]     count_q, count_d;
	logic [CW-1:0]     dirty_q, dirty_d;
	logic [CW-1:0]     ctr_q, ctr_d;
	logic [SW-1:0]     steps_q, steps_d;
	res_t              res_q, res_d;

	logic [CW-1:0] count_inc, dirty_inc;
	logic          node_in, in_parent_in, in_node_in, walk_in;
	link_t         new_link;

	assign count_inc = count_q + CW'(1);
	assign dirty_inc = dirty_q + CW'(1);

	// Range checks
	assign in_node_in   = KW'(req.node_index) < KW'(count_q);
	assign in_parent_in = KW'(req.parent_index) < KW'(count_q);
	assign node_in      = KW'(node_q) < KW'(count_q);
	assign walk_in      = KW'(rd_link.parent) < KW'(count_q);

	assign new_link = detach_q ? '{detached: 1'b1, parent: '0}
		: '{detached: 1'b0, parent: parent_q};

	assign res_valid = (state_q == ST_EMIT);
	assign res       = res_q;
	assign req.ready = (state_q == ST_IDLE);

	// State and payload registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			dirty_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			dirty_q <= dirty_d;
		end
	end

	always_ff @(posedge clk) begin
		mode_q   <= mode_d;
		node_q   <= node_d;
		parent_q <= parent_d;
		detach_q <= detach_d;
		pass_q   <= pass_d;
		ctr_q    <= ctr_d;
		steps_q  <= steps_d;
		res_q    <= res_d;
	end

	// Sequencer
	always_comb begin
		state_d    = state_q;
		mode_d     = mode_q;
		node_d     = node_q;
		parent_d   = parent_q;
		detach_d   = detach_q;
		pass_d     = pass_q;
		count_d    = count_q;
		dirty_d    = dirty_q;
		ctr_d      = ctr_q;
		steps_d    = steps_q;
		res_d      = res_q;
		mem_ctl    = '0;
		rd_addr    = '0;
		wr_addr    = '0;
		link_wdata = '{detached: 1'b1, parent: '0};

		unique case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					mode_d   = req.mode;
					node_d   = req.node_index;
					parent_d = req.parent_index;
					detach_d = req.detach;
					pass_d   = 1'b0;
					state_d  = ST_READ;
					case (req.mode)
						MODE_APPEND: begin
							state_d = ST_EMIT;
							if (count_q < ENT_C) begin
								mem_ctl.link_we     = 1'b1;
								mem_ctl.dirty_we    = 1'b1;
								mem_ctl.dirty_wdata = 1'b1;
								wr_addr             = AW'(count_q);
								count_d             = count_inc;
								dirty_d             = dirty_inc;
								res_d = '{ok: 1'b1, new_index: IDX_W'(count_q),
									node_parent: '0, node_detached: 1'b1,
									node_dirty: 1'b1, entry_count: OCNT_W'(count_inc),
									dirty_count: OCNT_W'(dirty_inc)};
							end else begin
								res_d = '{ok: 1'b0, new_index: '0, node_parent: '0,
									node_detached: 1'b1, node_dirty: 1'b0,
									entry_count: OCNT_W'(count_q),
									dirty_count: OCNT_W'(dirty_q)};
							end
						end
						MODE_ATTACH: begin
							if (in_node_in && !req.detach && in_parent_in
								&& (req.parent_index != req.node_index)) begin
								// first ancestry step reads the new parent's link
								mem_ctl.rd_en = 1'b1;
								rd_addr       = AW'(req.parent_index);
								steps_d       = SW'(1);
								state_d       = ST_WALK;
							end else begin
								pass_d = in_node_in && req.detach;
							end
						end
						MODE_CLEAR: begin
							dirty_d = '0;
							ctr_d   = '0;
							state_d = ST_SWEEP;
						end
						default: begin
						end
					endcase
				end
			end
			ST_SWEEP: begin
				// zero one dirty mark per cycle over the live entries
				if (ctr_q == count_q) begin
					state_d = ST_READ;
				end else begin
					mem_ctl.dirty_we    = 1'b1;
					mem_ctl.dirty_wdata = 1'b0;
					wr_addr             = AW'(ctr_q);
					ctr_d               = ctr_q + CW'(1);
				end
			end
			ST_WALK: begin
				// rd_link is the link of the previous chain member
				state_d = ST_READ;
				if (rd_link.detached) begin
					pass_d = (steps_q < LIM_C);
				end else if (steps_q >= LIM_C) begin
					pass_d = 1'b0;
				end else if (rd_link.parent == node_q) begin
					pass_d = 1'b0;
				end else if (!walk_in) begin
					pass_d = 1'b1;
				end else begin
					mem_ctl.rd_en = 1'b1;
					rd_addr       = AW'(rd_link.parent);
					steps_d       = steps_q + SW'(1);
					state_d       = ST_WALK;
				end
			end
			ST_READ: begin
				mem_ctl.rd_en = 1'b1;
				rd_addr       = AW'(node_q);
				state_d       = ST_NODE;
			end
			ST_NODE: begin
				// status of the addressed node; attach and touch report it after their update
				res_d.ok            = 1'b0;
				res_d.new_index     = '0;
				res_d.node_parent   = (node_in && !rd_link.detached) ? rd_link.parent : '0;
				res_d.node_detached = !node_in || rd_link.detached;
				res_d.node_dirty    = node_in && rd_dirty;
				case (mode_q)
					MODE_ATTACH: begin
						if (pass_q) begin
							mem_ctl.link_we     = 1'b1;
							mem_ctl.dirty_we    = 1'b1;
							mem_ctl.dirty_wdata = 1'b1;
							wr_addr             = AW'(node_q);
							link_wdata          = new_link;
							if (!rd_dirty) begin
								dirty_d = dirty_inc;
							end
							res_d.ok            = 1'b1;
							res_d.node_parent   = new_link.parent;
							res_d.node_detached = new_link.detached;
							res_d.node_dirty    = 1'b1;
						end
					end
					MODE_TOUCH: begin
						if (node_in) begin
							mem_ctl.dirty_we    = 1'b1;
							mem_ctl.dirty_wdata = 1'b1;
							wr_addr             = AW'(node_q);
							if (!rd_dirty) begin
								dirty_d = dirty_inc;
							end
							res_d.ok         = 1'b1;
							res_d.node_dirty = 1'b1;
						end
					end
					MODE_LOOKUP: res_d.ok = node_in;
					MODE_CLEAR:  res_d.ok = 1'b1;
					default: begin
					end
				endcase
				res_d.entry_count = OCNT_W'(count_q);
				res_d.dirty_count = OCNT_W'(dirty_d);
				state_d           = ST_EMIT;
			end
			ST_EMIT: begin
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	`PDM_ASSERT_HOLDS(a_dirty_le_count, clk, arst_n, dirty_q <= count_q, "dirty count above node count")
	`PDM_ASSERT_HOLDS(a_count_le_entries, clk, arst_n, count_q <= ENT_C, "node count above table size")
	`PDM_ASSERT_SAME(a_walk_steps, clk, arst_n, state_q == ST_WALK, (steps_q != '0) && (steps_q <= LIM_C), "walk step count out of bounds")
	`PDM_ASSERT_NEXT(a_emit_hold, clk, arst_n, (state_q == ST_EMIT) && !res_ready, (state_q == ST_EMIT) && $stable(res_q), "pending result lost")

endmodule

[rtl/parent_table_with_dirty_marks.sv]
// Parent table with dirty marks.
// req carries one command word: mode, node_index, parent_index, detach.
// rsp returns exactly one result word per command, in command order:
// ok, new_index, node_parent, node_detached, node_dirty, entry_count,
// dirty_count. Both channels use valid/ready; a word moves when both are high.
// Commands are processed one at a time against a link memory and a dirty-mark
// memory, each with a registered read.
// Append goes straight to its result; touch, lookup and unused modes read the
// node; attach first walks the ancestry, at most DEPTH_LIMIT link reads, then
// reads the node; clear first zeroes each stored node's mark, then reads it.
// req.ready returns in the cycle after the result leaves the sequencer.
// rsp is a registered output: a new command is accepted while a finished word
// waits there; if rsp stalls, the next result holds in the sequencer and
// req.ready stays low until the output register frees.
// Reset empties the table and zeroes both counts; memory contents are not
// cleared, entries are written by append before their read data is used.
module parent_table_with_dirty_marks #(
	parameter int ENTRIES = 64,
	parameter int DEPTH_LIMIT = 16
) (
	input logic       clk,
	input logic       arst_n,
	pdm_req_if.sink   req,
	pdm_rsp_if.source rsp
);
	import pdm_pkg::*;

	localparam int AW = $clog2(ENTRIES);

	mem_ctl_t      mem_ctl;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	link_t         link_wdata;
	link_t         rd_link;
	logic          rd_dirty;
	logic          res_valid;
	logic          res_ready;
	res_t          res;
	logic          rsp_valid_q;
	res_t          rsp_q;

	pdm_ctrl #(
		.ENTRIES     (ENTRIES),
		.DEPTH_LIMIT (DEPTH_LIMIT)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.mem_ctl    (mem_ctl),
		.rd_addr    (rd_addr),
		.wr_addr    (wr_addr),
		.link_wdata (link_wdata),
		.rd_link    (rd_link),
		.rd_dirty   (rd_dirty),
		.res_valid  (res_valid),
		.res        (res),
		.res_ready  (res_ready)
	);

	pdm_store #(
		.ENTRIES (ENTRIES)
	) u_store (
		.clk        (clk),
		.mem_ctl    (mem_ctl),
		.rd_addr    (rd_addr),
		.wr_addr    (wr_addr),
		.link_wdata (link_wdata),
		.rd_link    (rd_link),
		.rd_dirty   (rd_dirty)
	);

	// Output register
	assign res_ready = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_ready) begin
			rsp_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			rsp_q <= res;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.ok            = rsp_q.ok;
	assign rsp.new_index     = rsp_q.new_index;
	assign rsp.node_parent   = rsp_q.node_parent;
	assign rsp.node_detached = rsp_q.node_detached;
	assign rsp.node_dirty    = rsp_q.node_dirty;
	assign rsp.entry_count   = rsp_q.entry_count;
	assign rsp.dirty_count   = rsp_q.dirty_count;

endmodule
